@@ rtl/convex_quad_validity_check_defines.svh @@
// Assertion macros for the checker of the quad validity block.
`ifndef CONVEX_QUAD_VALIDITY_CHECK_DEFINES_SVH
`define CONVEX_QUAD_VALIDITY_CHECK_DEFINES_SVH

// Checked on every edge outside reset.
`define CQV_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define CQV_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/cqv_pkg.sv @@
package cqv_pkg;

   // Field widths
   localparam int COORD_BITS  = 24;
   localparam int EDGE_BITS   = 16;
   localparam int TURN_BITS   = 24;
   localparam int AREA_MIN_BITS = 32;
   localparam int TOL_BITS    = 20;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = 2;
   localparam int DENOM_FRAC  = 20;

   // Internal widths, all exact for full-range corners
   localparam int DIFF_BITS   = COORD_BITS + 1;          // corner differences
   localparam int SUM_BITS    = COORD_BITS + 2;          // alternating corner sums
   localparam int SQ_BITS     = 2 * DIFF_BITS;           // difference products
   localparam int CROSS_BITS  = SQ_BITS + 1;             // cross products, squared lengths
   localparam int AP_BITS     = 2 * COORD_BITS;          // coordinate products
   localparam int AREA_BITS   = AP_BITS + 3;             // doubled area
   localparam int GP_BITS     = SUM_BITS + DIFF_BITS;    // projective products
   localparam int TOP_BITS    = GP_BITS + 1;             // projective numerators
   localparam int BASE_BITS   = SQ_BITS + 1;             // base determinant
   localparam int DEN_BITS    = TOP_BITS + 2;            // scaled denominators
   localparam int BTOL_BITS   = BASE_BITS + TOL_BITS;
   localparam int SHIFT_BITS  = DEN_BITS + DENOM_FRAC;
   localparam int BLO_BITS    = 26;                      // low slice of |base|
   localparam int BHI_BITS    = BASE_BITS - BLO_BITS;    // high slice of |base|

   typedef enum logic [2:0] {
      FAIL_NONE     = 3'd0,
      FAIL_EDGE     = 3'd1,
      FAIL_TURN     = 3'd2,
      FAIL_WIND     = 3'd3,
      FAIL_AREA     = 3'd4,
      FAIL_SINGULAR = 3'd5,
      FAIL_DENOM    = 3'd6
   } fail_code_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MIN_EDGE   = 2'd0,
      CSR_MIN_TURN   = 2'd1,
      CSR_MIN_AREA   = 2'd2,
      CSR_DENOM_TOL  = 2'd3
   } csr_index_type;

   localparam logic [EDGE_BITS-1:0]     MIN_EDGE_RST  = 16'd2048;
   localparam logic [TURN_BITS-1:0]     MIN_TURN_RST  = 24'd262144;
   localparam logic [AREA_MIN_BITS-1:0] MIN_AREA_RST  = 32'd6553600;
   localparam logic [TOL_BITS-1:0]      DENOM_TOL_RST = 20'd10;

   typedef struct packed {
      logic [3:0][COORD_BITS-1:0] x;
      logic [3:0][COORD_BITS-1:0] y;
   } corners_type;

   // Products handed from the multiplier stages to the evaluation stages
   typedef struct packed {
      logic [3:0][SQ_BITS-1:0] sqx;
      logic [3:0][SQ_BITS-1:0] sqy;
      logic [3:0][SQ_BITS-1:0] cpa;
      logic [3:0][SQ_BITS-1:0] cpb;
      logic [3:0][AP_BITS-1:0] arp;
      logic [3:0][AP_BITS-1:0] arn;
      logic [GP_BITS-1:0]      g1;
      logic [GP_BITS-1:0]      g2;
      logic [GP_BITS-1:0]      h1;
      logic [GP_BITS-1:0]      h2;
      logic [SQ_BITS-1:0]      b1;
      logic [SQ_BITS-1:0]      b2;
      logic [2*EDGE_BITS-1:0]  edge_min2;
      logic                    projective;
   } prod_type;

   typedef struct packed {
      logic          is_valid;
      fail_code_type fail_code;
      logic [1:0]    fail_corner;
   } result_type;

endpackage

@@ rtl/cqv_if.sv @@
// Channel carrying one quad item
interface cqv_req_if;
   import cqv_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] corner0_x;
   logic [COORD_BITS-1:0] corner0_y;
   logic [COORD_BITS-1:0] corner1_x;
   logic [COORD_BITS-1:0] corner1_y;
   logic [COORD_BITS-1:0] corner2_x;
   logic [COORD_BITS-1:0] corner2_y;
   logic [COORD_BITS-1:0] corner3_x;
   logic [COORD_BITS-1:0] corner3_y;
   modport source (output valid, corner0_x, corner0_y, corner1_x, corner1_y,
                   corner2_x, corner2_y, corner3_x, corner3_y, input ready);
   modport sink   (input valid, corner0_x, corner0_y, corner1_x, corner1_y,
                   corner2_x, corner2_y, corner3_x, corner3_y, output ready);
endinterface

// Channel carrying one verdict item
interface cqv_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_valid;
   logic [2:0] fail_code;
   logic [1:0] fail_corner;
   modport source (output valid, is_valid, fail_code, fail_corner, input ready);
   modport sink   (input valid, is_valid, fail_code, fail_corner, output ready);
endinterface

// Register write channel
interface cqv_csr_if;
   import cqv_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/cqv_prod.sv @@
// Two stages: corner differences, then all products in parallel lanes.
module cqv_prod (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cqv_pkg::corners_type    in_data,
   input  logic [cqv_pkg::EDGE_BITS-1:0] min_edge_length,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cqv_pkg::prod_type       out_data
);
   import cqv_pkg::*;

   logic en1, en2;
   logic v1_ff, v2_ff;

   // stage 1 signals
   logic signed [COORD_BITS-1:0] xs [4];
   logic signed [COORD_BITS-1:0] ys [4];
   logic signed [DIFF_BITS-1:0]  ex_in [4];
   logic signed [DIFF_BITS-1:0]  ey_in [4];
   logic signed [SUM_BITS-1:0]   sx_in, sy_in;
   logic signed [DIFF_BITS-1:0]  ax1_in, ax2_in, ay1_in, ay2_in;

   logic signed [COORD_BITS-1:0] x_ff [4];
   logic signed [COORD_BITS-1:0] y_ff [4];
   logic signed [DIFF_BITS-1:0]  ex_ff [4];
   logic signed [DIFF_BITS-1:0]  ey_ff [4];
   logic signed [SUM_BITS-1:0]   sx_ff, sy_ff;
   logic signed [DIFF_BITS-1:0]  ax1_ff, ax2_ff, ay1_ff, ay2_ff;

   // stage 2 signals
   logic signed [SQ_BITS-1:0]  sqx_p [4];
   logic signed [SQ_BITS-1:0]  sqy_p [4];
   logic signed [SQ_BITS-1:0]  cpa_p [4];
   logic signed [SQ_BITS-1:0]  cpb_p [4];
   logic signed [AP_BITS-1:0]  arp_p [4];
   logic signed [AP_BITS-1:0]  arn_p [4];
   logic signed [GP_BITS-1:0]  g1_p, g2_p, h1_p, h2_p;
   logic signed [SQ_BITS-1:0]  b1_p, b2_p;
   prod_type                   prod_in;
   prod_type                   prod_ff;

   // bubble-collapsing stall chain
   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   // differences along the edges and for the projective terms
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         xs[i] = in_data.x[i];
         ys[i] = in_data.y[i];
      end
      for (int i = 0; i < 4; i++) begin
         ex_in[i] = xs[(i + 1) % 4] - xs[i];
         ey_in[i] = ys[(i + 1) % 4] - ys[i];
      end
      sx_in  = xs[0] - xs[1] + xs[2] - xs[3];
      sy_in  = ys[0] - ys[1] + ys[2] - ys[3];
      ax1_in = xs[1] - xs[2];
      ax2_in = xs[3] - xs[2];
      ay1_in = ys[1] - ys[2];
      ay2_in = ys[3] - ys[2];
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         for (int i = 0; i < 4; i++) begin
            x_ff[i]  <= xs[i];
            y_ff[i]  <= ys[i];
            ex_ff[i] <= ex_in[i];
            ey_ff[i] <= ey_in[i];
         end
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         ax1_ff <= ax1_in;
         ax2_ff <= ax2_in;
         ay1_ff <= ay1_in;
         ay2_ff <= ay2_in;
      end
   end

   // one multiplier per product
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sqx_p[i] = ex_ff[i] * ex_ff[i];
         sqy_p[i] = ey_ff[i] * ey_ff[i];
         cpa_p[i] = ex_ff[i] * ey_ff[(i + 1) % 4];
         cpb_p[i] = ey_ff[i] * ex_ff[(i + 1) % 4];
         arp_p[i] = x_ff[i] * y_ff[(i + 1) % 4];
         arn_p[i] = x_ff[(i + 1) % 4] * y_ff[i];
      end
      g1_p = sx_ff * ay2_ff;
      g2_p = ax2_ff * sy_ff;
      h1_p = ax1_ff * sy_ff;
      h2_p = sx_ff * ay1_ff;
      b1_p = ax1_ff * ay2_ff;
      b2_p = ax2_ff * ay1_ff;

      for (int i = 0; i < 4; i++) begin
         prod_in.sqx[i] = sqx_p[i];
         prod_in.sqy[i] = sqy_p[i];
         prod_in.cpa[i] = cpa_p[i];
         prod_in.cpb[i] = cpb_p[i];
         prod_in.arp[i] = arp_p[i];
         prod_in.arn[i] = arn_p[i];
      end
      prod_in.g1         = g1_p;
      prod_in.g2         = g2_p;
      prod_in.h1         = h1_p;
      prod_in.h2         = h2_p;
      prod_in.b1         = b1_p;
      prod_in.b2         = b2_p;
      prod_in.edge_min2  = min_edge_length * min_edge_length;
      prod_in.projective = (sx_ff != '0) || (sy_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (en2 && v1_ff) prod_ff <= prod_in;
   end

   assign out_valid = v2_ff;
   assign out_data  = prod_ff;

endmodule

@@ rtl/cqv_eval.sv @@
// Four stages: sums, magnitude tests, tolerance product, verdict.
module cqv_eval (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cqv_pkg::prod_type       in_data,
   input  logic [cqv_pkg::TURN_BITS-1:0]     min_turn_cross,
   input  logic [cqv_pkg::AREA_MIN_BITS-1:0] min_twice_area,
   input  logic [cqv_pkg::TOL_BITS-1:0]      denom_tolerance,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cqv_pkg::result_type     out_data
);
   import cqv_pkg::*;

   logic en1, en2, en3, en4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // stage 1
   logic [CROSS_BITS-1:0]        len2 [4];
   logic signed [SQ_BITS-1:0]    cpa_s [4];
   logic signed [SQ_BITS-1:0]    cpb_s [4];
   logic signed [AP_BITS-1:0]    arp_s [4];
   logic signed [AP_BITS-1:0]    arn_s [4];
   logic signed [GP_BITS-1:0]    g1_s, g2_s, h1_s, h2_s;
   logic signed [SQ_BITS-1:0]    b1_s, b2_s;
   logic [3:0]                   lenok_in;
   logic signed [CROSS_BITS-1:0] cr_in [4];
   logic signed [AP_BITS:0]      at_in [4];
   logic signed [TOP_BITS-1:0]   gtop_in, htop_in;
   logic signed [BASE_BITS-1:0]  base_in;

   logic [3:0]                   lenok1_ff;
   logic signed [CROSS_BITS-1:0] cr1_ff [4];
   logic signed [AP_BITS:0]      at1_ff [4];
   logic signed [TOP_BITS-1:0]   gtop1_ff, htop1_ff;
   logic signed [BASE_BITS-1:0]  base1_ff;
   logic                         proj1_ff;

   // stage 2
   logic [CROSS_BITS-1:0]        crabs [4];
   logic [3:0]                   turnok_in, pos_in;
   logic signed [AREA_BITS-1:0]  area_in;
   logic signed [DEN_BITS-1:0]   dn_in [4];
   logic [BASE_BITS-1:0]         absb_in;

   logic [3:0]                   lenok2_ff, turnok2_ff, pos2_ff;
   logic signed [AREA_BITS-1:0]  area2_ff;
   logic signed [DEN_BITS-1:0]   dn2_ff [4];
   logic [BASE_BITS-1:0]         absb2_ff;
   logic                         bzero2_ff, proj2_ff;

   // stage 3
   logic [AREA_BITS-1:0]         area_abs;
   fail_code_type                pre_code_in;
   logic [1:0]                   pre_corner_in;
   logic [DEN_BITS-1:0]          dabs_in [4];
   logic [3:0]                   dneg_in, dzero_in;
   logic [BLO_BITS+TOL_BITS-1:0] btlo_in;
   logic [BHI_BITS+TOL_BITS-1:0] bthi_in;

   fail_code_type                pre_code3_ff;
   logic [1:0]                   pre_corner3_ff;
   logic                         bzero3_ff, proj3_ff;
   logic [DEN_BITS-1:0]          dabs3_ff [4];
   logic [3:0]                   dneg3_ff, dzero3_ff;
   logic [BLO_BITS+TOL_BITS-1:0] btlo3_ff;
   logic [BHI_BITS+TOL_BITS-1:0] bthi3_ff;

   // stage 4
   logic [BTOL_BITS-1:0]         btol;
   logic [3:0]                   dok;
   result_type                   res_in;
   result_type                   res_ff;

   // stall chain, last stage is the output register
   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // stage 1: squared lengths with their test, cross products, area terms, projective terms
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cpa_s[i]    = in_data.cpa[i];
         cpb_s[i]    = in_data.cpb[i];
         arp_s[i]    = in_data.arp[i];
         arn_s[i]    = in_data.arn[i];
         len2[i]     = {1'b0, in_data.sqx[i]} + {1'b0, in_data.sqy[i]};
         lenok_in[i] = len2[i] >= CROSS_BITS'(in_data.edge_min2);
         cr_in[i]    = cpa_s[i] - cpb_s[i];
         at_in[i]    = arp_s[i] - arn_s[i];
      end
      g1_s    = in_data.g1;
      g2_s    = in_data.g2;
      h1_s    = in_data.h1;
      h2_s    = in_data.h2;
      b1_s    = in_data.b1;
      b2_s    = in_data.b2;
      gtop_in = g1_s - g2_s;
      htop_in = h1_s - h2_s;
      base_in = b1_s - b2_s;
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         lenok1_ff <= lenok_in;
         for (int i = 0; i < 4; i++) begin
            cr1_ff[i] <= cr_in[i];
            at1_ff[i] <= at_in[i];
         end
         gtop1_ff <= gtop_in;
         htop1_ff <= htop_in;
         base1_ff <= base_in;
         proj1_ff <= in_data.projective;
      end
   end

   // stage 2: turn magnitude and sign, area sum, corner denominators
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         crabs[i]     = cr1_ff[i][CROSS_BITS-1] ? CROSS_BITS'(-cr1_ff[i])
                                                : CROSS_BITS'(cr1_ff[i]);
         turnok_in[i] = crabs[i] >= CROSS_BITS'(min_turn_cross);
         pos_in[i]    = !cr1_ff[i][CROSS_BITS-1] && (cr1_ff[i] != '0);
      end
      area_in  = at1_ff[0] + at1_ff[1] + at1_ff[2] + at1_ff[3];
      dn_in[0] = base1_ff;
      dn_in[1] = base1_ff + gtop1_ff;
      dn_in[2] = base1_ff + gtop1_ff + htop1_ff;
      dn_in[3] = base1_ff + htop1_ff;
      absb_in  = base1_ff[BASE_BITS-1] ? BASE_BITS'(-base1_ff) : BASE_BITS'(base1_ff);
   end

   always_ff @(posedge clock) begin
      if (en2 && v1_ff) begin
         lenok2_ff  <= lenok1_ff;
         turnok2_ff <= turnok_in;
         pos2_ff    <= pos_in;
         area2_ff   <= area_in;
         for (int i = 0; i < 4; i++) dn2_ff[i] <= dn_in[i];
         absb2_ff   <= absb_in;
         bzero2_ff  <= (base1_ff == '0);
         proj2_ff   <= proj1_ff;
      end
   end

   // stage 3: first failing corner test, area test, tolerance partial products
   always_comb begin
      pre_code_in   = FAIL_NONE;
      pre_corner_in = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (pre_code_in == FAIL_NONE) begin
            if (!lenok2_ff[i]) begin
               pre_code_in   = FAIL_EDGE;
               pre_corner_in = 2'(i);
            end else if (!turnok2_ff[i]) begin
               pre_code_in   = FAIL_TURN;
               pre_corner_in = 2'(i);
            end else if (i != 0 && pos2_ff[i] != pos2_ff[0]) begin
               pre_code_in   = FAIL_WIND;
               pre_corner_in = 2'(i);
            end
         end
      end
      area_abs = area2_ff[AREA_BITS-1] ? AREA_BITS'(-area2_ff) : AREA_BITS'(area2_ff);
      if (pre_code_in == FAIL_NONE && area_abs < AREA_BITS'(min_twice_area))
         pre_code_in = FAIL_AREA;
      for (int i = 0; i < 4; i++) begin
         dneg_in[i]  = dn2_ff[i][DEN_BITS-1];
         dzero_in[i] = (dn2_ff[i] == '0);
         dabs_in[i]  = dn2_ff[i][DEN_BITS-1] ? DEN_BITS'(-dn2_ff[i])
                                             : DEN_BITS'(dn2_ff[i]);
      end
      // |base| split in two slices to keep each multiplier narrow
      btlo_in = absb2_ff[BLO_BITS-1:0] * denom_tolerance;
      bthi_in = absb2_ff[BASE_BITS-1:BLO_BITS] * denom_tolerance;
   end

   always_ff @(posedge clock) begin
      if (en3 && v2_ff) begin
         pre_code3_ff   <= pre_code_in;
         pre_corner3_ff <= pre_corner_in;
         bzero3_ff      <= bzero2_ff;
         proj3_ff       <= proj2_ff;
         for (int i = 0; i < 4; i++) dabs3_ff[i] <= dabs_in[i];
         dneg3_ff       <= dneg_in;
         dzero3_ff      <= dzero_in;
         btlo3_ff       <= btlo_in;
         bthi3_ff       <= bthi_in;
      end
   end

   // stage 4: denominator tests by cross-multiplication, final verdict
   always_comb begin
      btol = {bthi3_ff, {BLO_BITS{1'b0}}} + BTOL_BITS'(btlo3_ff);
      for (int i = 0; i < 4; i++) begin
         dok[i] = !dzero3_ff[i] && (dneg3_ff[i] == dneg3_ff[0]) &&
                  ({dabs3_ff[i], {DENOM_FRAC{1'b0}}} >= SHIFT_BITS'(btol));
      end
      res_in.fail_corner = pre_corner3_ff;
      if (pre_code3_ff != FAIL_NONE)
         res_in.fail_code = pre_code3_ff;
      else if (!proj3_ff)
         res_in.fail_code = FAIL_NONE;
      else if (bzero3_ff)
         res_in.fail_code = FAIL_SINGULAR;
      else if (dok != 4'hF)
         res_in.fail_code = FAIL_DENOM;
      else
         res_in.fail_code = FAIL_NONE;
      res_in.is_valid = (res_in.fail_code == FAIL_NONE);
   end

   always_ff @(posedge clock) begin
      if (en4 && v3_ff) res_ff <= res_in;
   end

   assign out_valid = v4_ff;
   assign out_data  = res_ff;

endmodule

@@ rtl/convex_quad_validity_check.sv @@
// Channel   Dir  Handshake     Item
// req_ch    in   valid/ready   four corners, x and y, signed 24 bits, 8 fraction bits
// rsp_ch    out  valid/ready   is_valid, fail_code, fail_corner
// csr_ch    in   valid/ready   register index and write data, always ready
//
// Six register stages: two for differences and products, four for sums,
// magnitude tests, the tolerance product and the verdict. One item enters
// per cycle unless stalled; rsp valid rises as the verdict register loads it.
// Each stage holds while its successor is full and stalled, so empty
// stages close up and a stalled result is held without loss.
// Synchronous reset empties the pipeline and restores the register defaults.
module convex_quad_validity_check (
   input logic        clock,
   input logic        reset,
   cqv_req_if.sink    req_ch,
   cqv_rsp_if.source  rsp_ch,
   cqv_csr_if.sink    csr_ch
);
   import cqv_pkg::*;

   logic [EDGE_BITS-1:0]     min_edge_length_ff;
   logic [TURN_BITS-1:0]     min_turn_cross_ff;
   logic [AREA_MIN_BITS-1:0] min_twice_area_ff;
   logic [TOL_BITS-1:0]      denom_tolerance_ff;

   corners_type corners;
   prod_type    prod;
   logic        prod_valid, prod_ready;
   result_type  result;

   // register file
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_edge_length_ff <= MIN_EDGE_RST;
         min_turn_cross_ff  <= MIN_TURN_RST;
         min_twice_area_ff  <= MIN_AREA_RST;
         denom_tolerance_ff <= DENOM_TOL_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_MIN_EDGE:  min_edge_length_ff <= csr_ch.data[EDGE_BITS-1:0];
            CSR_MIN_TURN:  min_turn_cross_ff  <= csr_ch.data[TURN_BITS-1:0];
            CSR_MIN_AREA:  min_twice_area_ff  <= csr_ch.data[AREA_MIN_BITS-1:0];
            CSR_DENOM_TOL: denom_tolerance_ff <= csr_ch.data[TOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // gather the corners of an item
   assign corners.x[0] = req_ch.corner0_x;
   assign corners.y[0] = req_ch.corner0_y;
   assign corners.x[1] = req_ch.corner1_x;
   assign corners.y[1] = req_ch.corner1_y;
   assign corners.x[2] = req_ch.corner2_x;
   assign corners.y[2] = req_ch.corner2_y;
   assign corners.x[3] = req_ch.corner3_x;
   assign corners.y[3] = req_ch.corner3_y;

   cqv_prod u_prod (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_ch.valid),
      .in_ready        (req_ch.ready),
      .in_data         (corners),
      .min_edge_length (min_edge_length_ff),
      .out_valid       (prod_valid),
      .out_ready       (prod_ready),
      .out_data        (prod)
   );

   cqv_eval u_eval (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (prod_valid),
      .in_ready        (prod_ready),
      .in_data         (prod),
      .min_turn_cross  (min_turn_cross_ff),
      .min_twice_area  (min_twice_area_ff),
      .denom_tolerance (denom_tolerance_ff),
      .out_valid       (rsp_ch.valid),
      .out_ready       (rsp_ch.ready),
      .out_data        (result)
   );

   assign rsp_ch.is_valid    = result.is_valid;
   assign rsp_ch.fail_code   = result.fail_code;
   assign rsp_ch.fail_corner = result.fail_corner;

endmodule

@@ rtl/cqv_checker.sv @@
`include "convex_quad_validity_check_defines.svh"

// Port-level checks on the verdict channel
module cqv_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       is_valid,
   input logic [2:0] fail_code,
   input logic [1:0] fail_corner
);
   import cqv_pkg::*;

   // pipeline is empty right after reset
   `CQV_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // a stalled verdict holds
   `CQV_ASSERT(a_stall_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(is_valid) && $stable(fail_code) && $stable(fail_corner)), "stalled result changed")

   // pass flag agrees with the code
   `CQV_ASSERT(a_valid_code, rsp_valid |-> (is_valid == (fail_code == FAIL_NONE)), "is_valid disagrees with fail_code")

   // only per-corner failures name a corner
   `CQV_ASSERT(a_corner_code, (rsp_valid && fail_corner != 2'd0) |-> (fail_code == FAIL_EDGE || fail_code == FAIL_TURN || fail_code == FAIL_WIND), "corner index on a non-corner code")

   // no code beyond the denominator failure
   `CQV_ASSERT(a_code_range, rsp_valid |-> (fail_code <= FAIL_DENOM), "undefined fail code")

endmodule

bind convex_quad_validity_check cqv_checker u_cqv_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .is_valid    (rsp_ch.is_valid),
   .fail_code   (rsp_ch.fail_code),
   .fail_corner (rsp_ch.fail_corner)
);

@@ tb/convex_quad_validity_check_tb.sv @@
`timescale 1ns / 1ps

import cqv_pkg::*;

// Holds the expected verdicts and the quad geometry predictor
class quad_verdict_board;
   typedef logic signed [127:0] wide_t;

   logic [EDGE_BITS-1:0]     min_edge;
   logic [TURN_BITS-1:0]     min_turn;
   logic [AREA_MIN_BITS-1:0] min_area;
   logic [TOL_BITS-1:0]      denom_tol;
   result_type               verdict_q[$];
   int                       mismatches;

   function void restore_defaults();
      min_edge  = MIN_EDGE_RST;
      min_turn  = MIN_TURN_RST;
      min_area  = MIN_AREA_RST;
      denom_tol = DENOM_TOL_RST;
   endfunction

   function void write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         CSR_MIN_EDGE:  min_edge  = value[EDGE_BITS-1:0];
         CSR_MIN_TURN:  min_turn  = value[TURN_BITS-1:0];
         CSR_MIN_AREA:  min_area  = value[AREA_MIN_BITS-1:0];
         CSR_DENOM_TOL: denom_tol = value[TOL_BITS-1:0];
         default: ;
      endcase
   endfunction

   function wide_t mag(wide_t v);
      return (v < 0) ? -v : v;
   endfunction

   // Denominator at one unit-square corner, scaled by the base determinant
   function bit denom_pass(wide_t scaled, wide_t base);
      wide_t tol;
      tol = 128'(denom_tol);
      if (scaled == 0 || ((scaled < 0) != (base < 0)))
         return 0;
      return (mag(scaled) <<< DENOM_FRAC) >= mag(base) * tol;
   endfunction

   function result_type predict(corners_type q);
      wide_t x[4], y[4];
      wide_t abx, aby, bcx, bcy, len2, cr, area, edge2;
      wide_t sx, sy, ax1, ax2, ay1, ay2, gtop, htop, base;
      wide_t turn_lim, area_lim;
      bit wind, pos;
      fail_code_type code;
      int where, j, k;
      result_type r;
      for (int i = 0; i < 4; i++) begin
         x[i] = 128'($signed(q.x[i]));
         y[i] = 128'($signed(q.y[i]));
      end
      code = FAIL_NONE;
      where = 0;
      wind = 0;
      area = 0;
      edge2 = 128'(min_edge);
      edge2 = edge2 * edge2;
      turn_lim = 128'(min_turn);
      area_lim = 128'(min_area);
      // per-corner edge, turn and winding tests
      for (int i = 0; i < 4; i++) begin
         j = (i + 1) % 4;
         k = (i + 2) % 4;
         abx = x[j] - x[i];
         aby = y[j] - y[i];
         bcx = x[k] - x[j];
         bcy = y[k] - y[j];
         len2 = abx * abx + aby * aby;
         if (len2 < edge2) begin
            code = FAIL_EDGE; where = i; break;
         end
         cr = abx * bcy - aby * bcx;
         if (mag(cr) < turn_lim) begin
            code = FAIL_TURN; where = i; break;
         end
         // a zero cross product counts as negative winding
         pos = cr > 0;
         if (i == 0)
            wind = pos;
         else if (pos != wind) begin
            code = FAIL_WIND; where = i; break;
         end
         area = area + x[i] * y[j] - x[j] * y[i];
      end
      if (code == FAIL_NONE && mag(area) < area_lim)
         code = FAIL_AREA;
      // projective terms; affine quads pass outright
      if (code == FAIL_NONE) begin
         sx = x[0] - x[1] + x[2] - x[3];
         sy = y[0] - y[1] + y[2] - y[3];
         if (sx != 0 || sy != 0) begin
            ax1 = x[1] - x[2]; ax2 = x[3] - x[2];
            ay1 = y[1] - y[2]; ay2 = y[3] - y[2];
            gtop = sx * ay2 - ax2 * sy;
            htop = ax1 * sy - sx * ay1;
            base = ax1 * ay2 - ax2 * ay1;
            if (base == 0)
               code = FAIL_SINGULAR;
            else if (!denom_pass(base, base) || !denom_pass(base + gtop, base) ||
                     !denom_pass(base + gtop + htop, base) ||
                     !denom_pass(base + htop, base))
               code = FAIL_DENOM;
         end
      end
      r.is_valid = (code == FAIL_NONE);
      r.fail_code = code;
      r.fail_corner = where[1:0];
      return r;
   endfunction

   function void note_quad(corners_type q);
      verdict_q.push_back(predict(q));
   endfunction

   function void check_verdict(logic is_valid, logic [2:0] fail_code, logic [1:0] fail_corner);
      result_type e;
      if (verdict_q.size() == 0) begin
         $error("verdict with no quad outstanding");
         mismatches++;
         return;
      end
      e = verdict_q.pop_front();
      if (is_valid !== e.is_valid) begin
         $error("is_valid: expected %0d, actual %0d", e.is_valid, is_valid);
         mismatches++;
      end
      if (fail_code !== e.fail_code) begin
         $error("fail_code: expected %0d, actual %0d", e.fail_code, fail_code);
         mismatches++;
      end
      if (fail_corner !== e.fail_corner) begin
         $error("fail_corner: expected %0d, actual %0d", e.fail_corner, fail_corner);
         mismatches++;
      end
   endfunction
endclass

module convex_quad_validity_check_tb;
   logic clock;
   logic reset;
   bit   req_idle_en;
   bit   rsp_idle_en;
   bit   long_hold_req;
   int   hold_left;
   quad_verdict_board board;

   cqv_req_if req_ch();
   cqv_rsp_if rsp_ch();
   cqv_csr_if csr_ch();

   convex_quad_validity_check DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Overall run limit
   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   // Check every verdict accepted
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_verdict(rsp_ch.is_valid, rsp_ch.fail_code, rsp_ch.fail_corner);
   end

   // Verdict receiver: random stall bursts and one long hold-off on request
   initial begin
      rsp_ch.ready = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 0;
            hold_left--;
         end else if (long_hold_req) begin
            long_hold_req = 0;
            hold_left = 79;
            rsp_ch.ready <= 0;
         end else if (rsp_idle_en && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 10);
            rsp_ch.ready <= 0;
         end else
            rsp_ch.ready <= 1;
      end
   end

   // Register write; valid is left high for back-to-back writes
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_ch.valid <= 1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      board.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic set_thresholds(logic [31:0] e, logic [31:0] t, logic [31:0] a,
                                 logic [31:0] d);
      write_csr(CSR_MIN_EDGE, e);
      write_csr(CSR_MIN_TURN, t);
      write_csr(CSR_MIN_AREA, a);
      write_csr(CSR_DENOM_TOL, d);
      csr_ch.valid <= 0;
   endtask

   // Offer one quad; valid is left high so items can go back to back
   task automatic send_quad(corners_type q);
      if (req_idle_en && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_ch.valid     <= 1;
      req_ch.corner0_x <= q.x[0];
      req_ch.corner0_y <= q.y[0];
      req_ch.corner1_x <= q.x[1];
      req_ch.corner1_y <= q.y[1];
      req_ch.corner2_x <= q.x[2];
      req_ch.corner2_y <= q.y[2];
      req_ch.corner3_x <= q.x[3];
      req_ch.corner3_y <= q.y[3];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_quad(q);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (board.verdict_q.size() > 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // Quad from pixel coordinates
   function automatic corners_type px_quad(int x0, int y0, int x1, int y1,
                                           int x2, int y2, int x3, int y3);
      corners_type q;
      q.x[0] = COORD_BITS'(x0 * 256); q.y[0] = COORD_BITS'(y0 * 256);
      q.x[1] = COORD_BITS'(x1 * 256); q.y[1] = COORD_BITS'(y1 * 256);
      q.x[2] = COORD_BITS'(x2 * 256); q.y[2] = COORD_BITS'(y2 * 256);
      q.x[3] = COORD_BITS'(x3 * 256); q.y[3] = COORD_BITS'(y3 * 256);
      return q;
   endfunction

   function automatic int rand_span(int j);
      return int'($urandom_range(0, 2 * j)) - j;
   endfunction

   // Random quad: mostly jittered convex boxes, some parallelograms,
   // some broken ones and some full-range noise
   function automatic corners_type rand_quad();
      corners_type q, t;
      int kind, r, j, cx, cy, lim, rot;
      int sgx[4], sgy[4];
      sgx = '{-1, 1, 1, -1};
      sgy = '{-1, -1, 1, 1};
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
         for (int i = 0; i < 4; i++) begin
            q.x[i] = COORD_BITS'($urandom);
            q.y[i] = COORD_BITS'($urandom);
         end
         return q;
      end
      case ($urandom_range(0, 3))
         0: r = $urandom_range(2 * 256, 64 * 256);
         1: r = $urandom_range(256, 16 * 256);
         2: r = $urandom_range(64 * 256, 4096 * 256);
         default: r = $urandom_range(1, 1 << 21);
      endcase
      lim = (1 << 23) - 1 - 2 * r;
      cx = rand_span(lim);
      cy = rand_span(lim);
      if (kind < 5) begin
         // exact parallelogram
         int ux, uy, vx, vy;
         ux = r; uy = rand_span(r / 2);
         vx = rand_span(r / 2); vy = r;
         q.x[0] = COORD_BITS'(cx - r); q.y[0] = COORD_BITS'(cy - r);
         q.x[1] = COORD_BITS'(cx - r + ux); q.y[1] = COORD_BITS'(cy - r + uy);
         q.x[2] = COORD_BITS'(cx - r + ux + vx); q.y[2] = COORD_BITS'(cy - r + uy + vy);
         q.x[3] = COORD_BITS'(cx - r + vx); q.y[3] = COORD_BITS'(cy - r + vy);
      end else begin
         j = (kind < 8) ? r : r / 2;
         for (int i = 0; i < 4; i++) begin
            q.x[i] = COORD_BITS'(cx + sgx[i] * r + rand_span(j));
            q.y[i] = COORD_BITS'(cy + sgy[i] * r + rand_span(j));
         end
      end
      // random orientation and starting corner
      if ($urandom_range(0, 1)) begin
         t = q; q.x[1] = t.x[3]; q.y[1] = t.y[3]; q.x[3] = t.x[1]; q.y[3] = t.y[1];
      end
      rot = $urandom_range(0, 3);
      t = q;
      for (int i = 0; i < 4; i++) begin
         q.x[i] = t.x[(i + rot) % 4];
         q.y[i] = t.y[(i + rot) % 4];
      end
      // broken: repeated or swapped corner
      if (kind == 19) begin
         j = $urandom_range(0, 3);
         q.x[j] = q.x[(j + 1) % 4];
         q.y[j] = q.y[(j + 1) % 4];
      end else if (kind == 18) begin
         t = q; q.x[1] = t.x[2]; q.y[1] = t.y[2]; q.x[2] = t.x[1]; q.y[2] = t.y[1];
      end
      return q;
   endfunction

   task automatic run_random(int count, bit pressure);
      for (int n = 0; n < count; n++) begin
         if (pressure && n == 40)
            long_hold_req = 1;
         if (pressure && n == 150) begin
            // hold off until every verdict has come back
            drain();
         end
         send_quad(rand_quad());
      end
      drain();
   endtask

   initial begin
      corners_type q;
      board = new();
      board.restore_defaults();
      board.mismatches = 0;
      long_hold_req = 0;
      req_idle_en = 1;
      rsp_idle_en = 1;
      req_ch.valid = 0;
      req_ch.corner0_x = '0; req_ch.corner0_y = '0;
      req_ch.corner1_x = '0; req_ch.corner1_y = '0;
      req_ch.corner2_x = '0; req_ch.corner2_y = '0;
      req_ch.corner3_x = '0; req_ch.corner3_y = '0;
      csr_ch.valid = 0;
      csr_ch.index = CSR_MIN_EDGE;
      csr_ch.data = '0;
      reset = 1;
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed quads at reset thresholds
      send_quad(px_quad(0, 0, 100, 0, 100, 100, 0, 100));      // square, ccw
      send_quad(px_quad(0, 0, 0, 100, 100, 100, 100, 0));      // square, cw
      send_quad(px_quad(0, 0, 9, 0, 9, 9, 0, 9));              // small square
      send_quad(px_quad(0, 0, 0, 0, 100, 100, 0, 100));        // repeated corner
      send_quad(px_quad(0, 0, 50, 0, 100, 0, 0, 100));         // collinear corner
      send_quad(px_quad(0, 0, 100, 100, 100, 0, 0, 100));      // bow tie
      send_quad(px_quad(0, 0, 100, 0, 60, 50, 0, 100));        // convex, corner 2 pushed out
      send_quad(px_quad(0, 0, 100, 20, 130, 120, 30, 100));    // parallelogram
      send_quad(px_quad(0, 0, 400, 0, 220, 30, 180, 30));      // strong taper
      send_quad(px_quad(-20, -20, 1000, -10, 900, 950, 5, 700));
      for (int i = 0; i < 4; i++) begin
         q.x[i] = (i == 1 || i == 2) ? 24'h7fffff : 24'h800000;
         q.y[i] = (i >= 2) ? 24'h7fffff : 24'h800000;
      end
      send_quad(q);                                            // full-range square
      q.x[2] = 24'h000000;
      send_quad(q);
      for (int i = 0; i < 4; i++) begin
         q.x[i] = 24'hffffff;
         q.y[i] = 24'h000000;
      end
      send_quad(q);                                            // all corners equal
      run_random(250, 1);

      // lowest thresholds: zero turn and zero denominator cases
      set_thresholds(0, 0, 0, 0);
      send_quad(px_quad(0, 0, 50, 0, 100, 0, 0, 100));         // zero cross product
      send_quad(px_quad(0, 0, 100, 0, 200, 0, 300, 0));        // all collinear
      send_quad(px_quad(0, 0, 0, 0, 0, 0, 0, 0));
      send_quad(px_quad(0, 0, 100, 0, 50, 50, 0, 100));        // singular base
      send_quad(px_quad(0, 0, 100, 0, 50, 50, 50, 100));
      run_random(270, 0);

      // highest thresholds
      set_thresholds(32'hffff, 32'hffffff, 32'hffffffff, 32'hfffff);
      run_random(270, 0);

      // mid thresholds with denominator tolerance near one, then one half
      set_thresholds(512, 1000, 100000, 32'hfffff);
      run_random(135, 0);
      set_thresholds(1024, 65536, 1 << 20, 1 << 19);
      run_random(135, 0);

      // reset thresholds again, no idling at the end
      set_thresholds(32'(MIN_EDGE_RST), 32'(MIN_TURN_RST), 32'(MIN_AREA_RST),
                     32'(DENOM_TOL_RST));
      req_idle_en = 0;
      rsp_idle_en = 0;
      run_random(270, 0);

      repeat (20) @(negedge clock);
      if (board.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

@@ files.f @@
+incdir+rtl
rtl/cqv_pkg.sv
rtl/cqv_if.sv
rtl/cqv_prod.sv
rtl/cqv_eval.sv
rtl/convex_quad_validity_check.sv
rtl/cqv_checker.sv
tb/convex_quad_validity_check_tb.sv
